>>> sv/mfk_pkg.sv
// Shared types, constants and helpers for the six-axis forward kinematics block.
// Depends on nothing; every other file of the block imports it.
package mfk_pkg;

   // Geometry and field widths.
   localparam int NJ         = 6;
   localparam int JIDX_W     = 3;
   localparam int ANG_W      = 16;
   localparam int ROT_W      = 16;
   localparam int POS_W      = 32;
   localparam int LEN_W      = 20;
   localparam int OFS_W      = 20;
   localparam int PARAM_W    = 56;
   localparam int REQ_W      = NJ * ANG_W;
   localparam int RSP_W      = 9 * ROT_W + 3 * POS_W;

   // CORDIC settings.
   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int CW           = 34;
   localparam logic [31:0] KEEP_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
   localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [ROT_W-1:0] ONE_Q14 = 16'sd16384;

   // Front feed: six joint angles, then six twists.
   localparam int NFEED  = 2 * NJ;
   localparam int FEED_W = 4;

   // Queue between front and back.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   // Back sequencer steps within one joint.
   localparam int STEP_W       = 5;
   localparam int ST_T10       = 0;
   localparam int ST_T11       = 1;
   localparam int ST_T20       = 2;
   localparam int ST_T21       = 3;
   localparam int ST_P1        = 4;
   localparam int ST_P2        = 5;
   localparam int ST_ROT_FIRST = 7;
   localparam int ST_ROT_LAST  = 15;
   localparam int ST_POS_FIRST = 16;
   localparam int ST_POS_LAST  = 18;
   localparam int ST_COMMIT    = 20;

   typedef struct packed {
      logic signed [ROT_W-1:0] s;
      logic signed [ROT_W-1:0] c;
   } sincos_type;

   typedef struct packed {
      sincos_type q;
      sincos_type a;
   } joint_trig_type;

   typedef joint_trig_type [NJ-1:0] trig_set_type;

   // Arctangent table, full turn = 2^32.
   function automatic logic [31:0] atan_entry(input int i);
      logic [31:0] v;
      case (i)
         0:  v = 32'h20000000;
         1:  v = 32'h12E4051E;
         2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;
         4:  v = 32'h028B0D43;
         5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;
         7:  v = 32'h00517C55;
         8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2F;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2FA;
         15: v = 32'h0000517D;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A30;
         19: v = 32'h00000518;
         20: v = 32'h0000028C;
         21: v = 32'h00000146;
         22: v = 32'h000000A3;
         23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -64'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Negation that saturates the most negative value.
   function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
      logic signed [15:0] r;
      if (v == 16'sh8000) begin
         r = 16'sh7FFF;
      end else begin
         r = -v;
      end
      return r;
   endfunction

endpackage

>>> sv/mfk_cordic.sv
// Pipelined CORDIC in rotation mode: one binary angle in per cycle, sine and cosine out.
// Depends on mfk_pkg for widths, the arctangent table and saturation.
module mfk_cordic import mfk_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [ANG_W-1:0] in_angle,
   output logic             out_valid,
   output sincos_type       out_sc
);

   logic signed [CW-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] z_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] x_in [0:CORDIC_STEPS];
   logic signed [CW-1:0] y_in [0:CORDIC_STEPS];
   logic signed [CW-1:0] z_in [0:CORDIC_STEPS];
   logic                 flip_ff [0:CORDIC_STEPS];
   logic                 vld_ff  [0:CORDIC_STEPS];

   logic [31:0]          phase;
   logic [31:0]          phase_fold;
   logic                 flip_in;
   logic signed [CW-1:0] xf;
   logic signed [CW-1:0] yf;
   logic signed [CW:0]   xr;
   logic signed [CW:0]   yr;
   logic                 out_valid_ff;
   sincos_type           out_sc_ff;

   // Quadrant fold: angles in the left half plane are turned by pi.
   always_comb begin
      phase      = {in_angle, 16'h0000} & KEEP_MASK;
      flip_in    = phase[31] ^ phase[30];
      phase_fold = flip_in ? (phase ^ 32'h80000000) : phase;
      x_in[0]    = GAIN_Q30;
      y_in[0]    = '0;
      z_in[0]    = {{(CW-32){phase_fold[31]}}, phase_fold};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= x_in[0];
      y_ff[0]    <= y_in[0];
      z_ff[0]    <= z_in[0];
      flip_ff[0] <= flip_in;
   end

   // One micro-rotation per stage.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
      logic signed [CW-1:0] t;

      always_comb begin
         t = {{(CW-32){1'b0}}, atan_entry(i) & KEEP_MASK};
         if (z_ff[i][CW-1]) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + t;
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - t;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i+1]    <= x_in[i+1];
         y_ff[i+1]    <= y_in[i+1];
         z_ff[i+1]    <= z_in[i+1];
         flip_ff[i+1] <= flip_ff[i];
      end
   end

   // Undo the fold, round Q2.30 to Q1.14 and saturate.
   always_comb begin
      xf = flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
      yf = flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
      xr = (CW+1)'(xf) + (CW+1)'(32768);
      yr = (CW+1)'(yf) + (CW+1)'(32768);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vld_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      out_sc_ff.c <= sat16(64'(xr >>> 16));
      out_sc_ff.s <= sat16(64'(yr >>> 16));
   end

   assign out_valid = out_valid_ff;
   assign out_sc    = out_sc_ff;

endmodule

>>> sv/mfk_front.sv
// Front end: takes a pose request, runs its joint angles and the twists through the
// CORDIC and collects the twelve sine/cosine pairs into one queue entry. Uses mfk_pkg.
module mfk_front import mfk_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_W-1:0]           req_tdata,
   input  logic [NJ-1:0][ANG_W-1:0]   twist,
   input  logic                       pop,
   output logic                       push_valid,
   output trig_set_type               push_data
);

   logic [NJ-1:0][ANG_W-1:0] ang_ff;
   logic                     busy_ff;
   logic [FEED_W-1:0]        feed_ff;
   logic [FEED_W-1:0]        res_ff;
   logic [QCNT_W-1:0]        out_ff;
   logic [FEED_W-1:0]        tw_idx;
   logic [ANG_W-1:0]         feed_angle;
   logic                     accept;
   logic                     cd_valid;
   sincos_type               cd_sc;
   sincos_type               asm_ff [0:NFEED-1];
   sincos_type               asm_in [0:NFEED-1];

   // Items held anywhere between this input and the queue head are counted so the
   // queue can never overflow.
   assign req_tready = !busy_ff && (out_ff < QCNT_W'(QDEPTH));
   assign accept     = req_tvalid && req_tready;

   // Angle fed to the CORDIC this cycle: joint angles first, then twists.
   always_comb begin
      tw_idx = feed_ff - FEED_W'(NJ);
      if (feed_ff < FEED_W'(NJ)) begin
         feed_angle = ang_ff[feed_ff[JIDX_W-1:0]];
      end else begin
         feed_angle = twist[tw_idx[JIDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         feed_ff <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         feed_ff <= '0;
      end else if (busy_ff) begin
         if (feed_ff == FEED_W'(NFEED - 1)) begin
            busy_ff <= 1'b0;
         end
         feed_ff <= feed_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ang_ff <= req_tdata;
      end
   end

   // Outstanding item count.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else if (accept && !pop) begin
         out_ff <= out_ff + 1'b1;
      end else if (!accept && pop) begin
         out_ff <= out_ff - 1'b1;
      end
   end

   mfk_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (busy_ff),
      .in_angle  (feed_angle),
      .out_valid (cd_valid),
      .out_sc    (cd_sc)
   );

   // Collect CORDIC results in feed order.
   always_comb begin
      asm_in = asm_ff;
      if (cd_valid) begin
         asm_in[res_ff] = cd_sc;
      end
      for (int j = 0; j < NJ; j++) begin
         push_data[j].q = asm_in[j];
         push_data[j].a = asm_in[NJ + j];
      end
   end

   assign push_valid = cd_valid && (res_ff == FEED_W'(NFEED - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else if (cd_valid) begin
         if (res_ff == FEED_W'(NFEED - 1)) begin
            res_ff <= '0;
         end else begin
            res_ff <= res_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      asm_ff <= asm_in;
   end

endmodule

>>> sv/mfk_queue.sv
// Short FIFO of sine/cosine sets between the front end and the back end.
// Uses mfk_pkg for the entry type and depth.
module mfk_queue import mfk_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  trig_set_type      push_data,
   input  logic              pop,
   output logic              out_valid,
   output trig_set_type      out_data,
   output logic [QCNT_W-1:0] count
);

   trig_set_type      mem_ff [0:QDEPTH-1];
   logic [QPTR_W-1:0] wr_ff;
   logic [QPTR_W-1:0] rd_ff;
   logic [QCNT_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (!push && pop) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign count     = cnt_ff;

endmodule

>>> sv/mfk_back.sv
// Back end: chains the six joint transforms with one shared three-term dot-product
// unit and holds the finished pose in the output register. Uses mfk_pkg.
module mfk_back import mfk_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  trig_set_type               q_data,
   output logic                       q_pop,
   input  logic [NJ-1:0][PARAM_W-1:0] params,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_W-1:0]           rsp_tdata
);

   typedef enum logic [1:0] {K_TRIG, K_ROT, K_POS} kind_type;

   logic                      busy_ff;
   logic [JIDX_W-1:0]         joint_ff;
   logic [STEP_W-1:0]         step_ff;
   logic signed [ROT_W-1:0]   r_ff  [0:8];
   logic signed [ROT_W-1:0]   nr_ff [0:8];
   logic signed [POS_W-1:0]   p_ff  [0:2];
   logic signed [POS_W-1:0]   np_ff [0:2];
   logic signed [ROT_W-1:0]   t10_ff, t11_ff, t20_ff, t21_ff;
   logic signed [POS_W-1:0]   p1_ff, p2_ff;
   logic signed [ROT_W-1:0]   rot_ff [0:8];
   logic signed [POS_W-1:0]   pos_ff [0:2];
   logic                      rsp_valid_ff;

   joint_trig_type            jt;
   logic [PARAM_W-1:0]        jp;
   logic signed [ROT_W-1:0]   tm [0:8];
   logic signed [POS_W:0]     pv [0:2];
   logic signed [POS_W:0]     ofs;
   logic [STEP_W-1:0]         sub;
   logic [1:0]                row;
   logic [1:0]                col;
   logic signed [ROT_W-1:0]   ra [0:2];
   logic signed [ROT_W-1:0]   tc [0:2];
   logic signed [POS_W-1:0]   prow;

   // Issue side of the dot-product unit.
   logic                      iss;
   logic signed [ROT_W-1:0]   a_op [0:2];
   logic signed [POS_W:0]     b_op [0:2];
   kind_type                  kind;
   logic [3:0]                idx;
   logic                      neg;
   logic                      s16;
   logic signed [POS_W:0]     addend;

   // Product stage.
   logic signed [48:0]        prod_ff [0:2];
   logic                      dv_ff;
   kind_type                  kind_ff;
   logic [3:0]                idx_ff;
   logic                      neg_ff;
   logic                      s16_ff;
   logic signed [POS_W:0]     add_ff;

   logic signed [51:0]        sum;
   logic signed [51:0]        rnd;
   logic signed [52:0]        val;
   logic signed [POS_W-1:0]   res;
   logic                      last;
   logic                      can_out;

   // Current joint's trig values and parameters.
   always_comb begin
      jt  = q_data[joint_ff];
      jp  = params[joint_ff];
      ofs = (POS_W+1)'($signed(jp[LEN_W+OFS_W-1:LEN_W]));
      tm[0] = jt.q.c;
      tm[1] = neg_sat16(jt.q.s);
      tm[2] = '0;
      tm[3] = t10_ff;
      tm[4] = t11_ff;
      tm[5] = neg_sat16(jt.a.s);
      tm[6] = t20_ff;
      tm[7] = t21_ff;
      tm[8] = jt.a.c;
      pv[0] = {{(POS_W+1-LEN_W){1'b0}}, jp[LEN_W-1:0]};
      pv[1] = (POS_W+1)'(p1_ff);
      pv[2] = (POS_W+1)'(p2_ff);
   end

   // Row and column selection for the rotation and position dot products.
   always_comb begin
      if (step_ff >= STEP_W'(ST_POS_FIRST)) begin
         sub = step_ff - STEP_W'(ST_POS_FIRST);
      end else begin
         sub = step_ff - STEP_W'(ST_ROT_FIRST);
      end
      case (sub)
         5'd0:    begin row = 2'd0; col = 2'd0; end
         5'd1:    begin row = 2'd0; col = 2'd1; end
         5'd2:    begin row = 2'd0; col = 2'd2; end
         5'd3:    begin row = 2'd1; col = 2'd0; end
         5'd4:    begin row = 2'd1; col = 2'd1; end
         5'd5:    begin row = 2'd1; col = 2'd2; end
         5'd6:    begin row = 2'd2; col = 2'd0; end
         5'd7:    begin row = 2'd2; col = 2'd1; end
         5'd8:    begin row = 2'd2; col = 2'd2; end
         default: begin row = 2'd0; col = 2'd0; end
      endcase
      if (step_ff >= STEP_W'(ST_POS_FIRST)) begin
         row = sub[1:0];
      end
      case (row)
         2'd0:    begin ra[0] = r_ff[0]; ra[1] = r_ff[1]; ra[2] = r_ff[2]; prow = p_ff[0]; end
         2'd1:    begin ra[0] = r_ff[3]; ra[1] = r_ff[4]; ra[2] = r_ff[5]; prow = p_ff[1]; end
         default: begin ra[0] = r_ff[6]; ra[1] = r_ff[7]; ra[2] = r_ff[8]; prow = p_ff[2]; end
      endcase
      case (col)
         2'd0:    begin tc[0] = tm[0]; tc[1] = tm[3]; tc[2] = tm[6]; end
         2'd1:    begin tc[0] = tm[1]; tc[1] = tm[4]; tc[2] = tm[7]; end
         default: begin tc[0] = tm[2]; tc[1] = tm[5]; tc[2] = tm[8]; end
      endcase
   end

   // Operand selection by sequencer step.
   always_comb begin
      iss    = 1'b0;
      kind   = K_TRIG;
      idx    = '0;
      neg    = 1'b0;
      s16    = 1'b0;
      addend = '0;
      for (int k = 0; k < 3; k++) begin
         a_op[k] = '0;
         b_op[k] = '0;
      end
      if (busy_ff) begin
         if (step_ff <= STEP_W'(ST_P2)) begin
            iss  = 1'b1;
            kind = K_TRIG;
            idx  = step_ff[3:0];
            s16  = 1'b1;
            case (step_ff)
               STEP_W'(ST_T10): begin
                  a_op[0] = jt.q.s;
                  b_op[0] = (POS_W+1)'(jt.a.c);
               end
               STEP_W'(ST_T11): begin
                  a_op[0] = jt.q.c;
                  b_op[0] = (POS_W+1)'(jt.a.c);
               end
               STEP_W'(ST_T20): begin
                  a_op[0] = jt.q.s;
                  b_op[0] = (POS_W+1)'(jt.a.s);
               end
               STEP_W'(ST_T21): begin
                  a_op[0] = jt.q.c;
                  b_op[0] = (POS_W+1)'(jt.a.s);
               end
               STEP_W'(ST_P1): begin
                  a_op[0] = jt.a.s;
                  b_op[0] = ofs;
                  neg     = 1'b1;
                  s16     = 1'b0;
               end
               default: begin
                  a_op[0] = jt.a.c;
                  b_op[0] = ofs;
                  s16     = 1'b0;
               end
            endcase
         end else if (step_ff >= STEP_W'(ST_ROT_FIRST) &&
                      step_ff <= STEP_W'(ST_ROT_LAST)) begin
            iss  = 1'b1;
            kind = K_ROT;
            idx  = sub[3:0];
            s16  = 1'b1;
            for (int k = 0; k < 3; k++) begin
               a_op[k] = ra[k];
               b_op[k] = (POS_W+1)'(tc[k]);
            end
         end else if (step_ff >= STEP_W'(ST_POS_FIRST) &&
                      step_ff <= STEP_W'(ST_POS_LAST)) begin
            iss    = 1'b1;
            kind   = K_POS;
            idx    = sub[3:0];
            addend = (POS_W+1)'(prow);
            for (int k = 0; k < 3; k++) begin
               a_op[k] = ra[k];
               b_op[k] = pv[k];
            end
         end
      end
   end

   // Product stage of the dot-product unit.
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
      end else begin
         dv_ff <= iss;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         prod_ff[k] <= a_op[k] * b_op[k];
      end
      kind_ff <= kind;
      idx_ff  <= idx;
      neg_ff  <= neg;
      s16_ff  <= s16;
      add_ff  <= addend;
   end

   // Sum, Q1.14 rounding, then negation or the position addend, and saturation.
   always_comb begin
      sum = 52'(prod_ff[0]) + 52'(prod_ff[1]) + 52'(prod_ff[2]);
      rnd = (sum + 52'sd8192) >>> 14;
      if (neg_ff) begin
         val = -53'(rnd);
      end else begin
         val = 53'(rnd) + 53'(add_ff);
      end
      if (s16_ff) begin
         res = 32'(sat16(64'(val)));
      end else begin
         res = sat32(64'(val));
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ff) begin
         case (kind_ff)
            K_TRIG: begin
               case (idx_ff)
                  4'(ST_T10): t10_ff <= res[ROT_W-1:0];
                  4'(ST_T11): t11_ff <= res[ROT_W-1:0];
                  4'(ST_T20): t20_ff <= res[ROT_W-1:0];
                  4'(ST_T21): t21_ff <= res[ROT_W-1:0];
                  4'(ST_P1):  p1_ff  <= res;
                  default:    p2_ff  <= res;
               endcase
            end
            K_ROT:   nr_ff[idx_ff] <= res[ROT_W-1:0];
            default: np_ff[idx_ff[1:0]] <= res;
         endcase
      end
   end

   // Sequencer: 21 steps per joint, six joints per pose.
   assign last    = busy_ff && (step_ff == STEP_W'(ST_COMMIT)) &&
                    (joint_ff == JIDX_W'(NJ - 1));
   assign can_out = !rsp_valid_ff || rsp_tready;
   assign q_pop   = last && can_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         joint_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (!busy_ff) begin
            if (q_valid) begin
               busy_ff  <= 1'b1;
               joint_ff <= '0;
               step_ff  <= '0;
            end
         end else if (step_ff == STEP_W'(ST_COMMIT)) begin
            if (joint_ff == JIDX_W'(NJ - 1)) begin
               if (can_out) begin
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end
            end else begin
               joint_ff <= joint_ff + 1'b1;
               step_ff  <= '0;
            end
         end else begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   // Running pose and the output register.
   always_ff @(posedge clock) begin
      if (!busy_ff && q_valid) begin
         for (int i = 0; i < 9; i++) begin
            r_ff[i] <= (i % 4 == 0) ? ONE_Q14 : '0;
         end
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= '0;
         end
      end else if (busy_ff && step_ff == STEP_W'(ST_COMMIT)) begin
         r_ff <= nr_ff;
         p_ff <= np_ff;
      end
      if (q_pop) begin
         rot_ff <= nr_ff;
         pos_ff <= np_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         rsp_tdata[i*ROT_W +: ROT_W] = rot_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         rsp_tdata[9*ROT_W + i*POS_W +: POS_W] = pos_ff[i];
      end
   end

endmodule

>>> sv/mdh_forward_kinematics_6axis_top.sv
// Top level of the six-axis modified-DH forward kinematics block.
// Holds the joint parameter registers and joins mfk_front, mfk_queue and mfk_back.
//
// A pose request carries six binary joint angles; the response carries the 3x3
// rotation in Q1.14 and the end position in length units, one response per request,
// in order. The front end pushes twelve angles (six joints, six twists) through a
// pipelined CORDIC, one per cycle, and hands the sine/cosine set to a two-entry
// queue once all twelve results are back. The back end chains the six joint
// transforms through one shared dot-product unit of three multipliers and
// finishes one pose before it starts the next, so that unit sets the sustained
// pose rate. Requests are taken while earlier poses are still in the back end
// or waiting at the output register. Joint parameters must be written through the
// csr port only while no pose is in flight; the block itself does not enforce it.
module mdh_forward_kinematics_6axis_top import mfk_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // Pose request.
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,   // joint1_angle .. joint6_angle, 16 bits each
   // Pose response.
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,   // rot_00 .. rot_22 (16b), pos_x, pos_y, pos_z (32b)
   // Parameter register writes.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [JIDX_W-1:0]  csr_index,
   input  logic [PARAM_W-1:0] csr_wdata
);

   logic [NJ-1:0][PARAM_W-1:0] params_ff;
   logic [NJ-1:0][ANG_W-1:0]   twist;
   logic                       q_push;
   trig_set_type               q_push_data;
   logic                       q_pop;
   logic                       q_valid;
   trig_set_type               q_data;
   logic [QCNT_W-1:0]          q_count;

   // Parameter registers; indexes past the last joint are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         params_ff <= '0;
      end else if (csr_valid && csr_index < JIDX_W'(NJ)) begin
         params_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int j = 0; j < NJ; j++) begin
         twist[j] = params_ff[j][PARAM_W-1:LEN_W+OFS_W];
      end
   end

   mfk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .twist      (twist),
      .pop        (q_pop),
      .push_valid (q_push),
      .push_data  (q_push_data)
   );

   mfk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_data  (q_data),
      .count     (q_count)
   );

   mfk_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .params     (params_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // The front end's credit count must keep the queue from overflowing.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < QCNT_W'(QDEPTH) || q_pop))
      else $error("queue push while full");

   // The back end only retires a set that is in the queue.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue pop while empty");

   // A request transfer starts a twelve-angle feed, so the next cycle is not ready.
   a_feed_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken during angle feed");

endmodule

>>> sim/tb_mdh_forward_kinematics_6axis_top.sv
// Self-checking bench for the six-axis modified-DH forward kinematics block.
// Depends on mfk_pkg and mdh_forward_kinematics_6axis_top; it predicts every pose itself.
`timescale 1ns / 100ps

module tb_mdh_forward_kinematics_6axis_top import mfk_pkg::*;;

   // Pose fields as they travel on the response bus.
   typedef struct {
      logic signed [15:0] rot [9];
      logic signed [31:0] pos [3];
   } pose_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [JIDX_W-1:0]  csr_index = '0;
   logic [PARAM_W-1:0] csr_wdata = '0;

   mdh_forward_kinematics_6axis_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the joint parameter registers.
   logic [55:0]        joint_word [6];
   logic [REQ_W-1:0]   pose_requests [$];
   pose_type           expected_poses [$];
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 error_count = 0;
   int                 quiet_cycles = 0;
   bit                 done = 1'b0;
   bit                 req_taken = 1'b0;

   // Arithmetic shift with floor, on 64-bit values.
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp16(longint v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
   endfunction

   function automatic longint clamp32(longint v);
      return v > 64'sd2147483647 ? 64'sd2147483647 :
             (v < -64'sd2147483648 ? -64'sd2147483648 : v);
   endfunction

   function automatic longint round_q14(longint v);
      return floor_shift(v + 8192, 14);
   endfunction

   // Fixed-step CORDIC on a 16-bit binary angle, results in Q1.14.
   function automatic void cordic_sincos(input logic [15:0] angle, output longint s_out,
                                         output longint c_out);
      logic [31:0] phase;
      logic [31:0] step_angle;
      bit          fold;
      longint      x, y, z, nx;
      phase = {angle, 16'h0} & KEEP_MASK;
      fold = phase[31] != phase[30];
      if (fold) begin
         phase = phase + 32'h80000000;
      end
      z = longint'($signed(phase));
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         step_angle = atan_entry(i) & KEEP_MASK;
         if (z >= 0) begin
            nx = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z = z - longint'(step_angle);
         end else begin
            nx = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z = z + longint'(step_angle);
         end
         x = nx;
      end
      if (fold) begin
         x = -x;
         y = -y;
      end
      c_out = clamp16(floor_shift(x + 32768, 16));
      s_out = clamp16(floor_shift(y + 32768, 16));
   endfunction

   // Chains the six joint transforms into the end pose.
   function automatic pose_type chain_pose(logic [REQ_W-1:0] angles);
      pose_type pose;
      longint rot [3][3];
      longint pos [3];
      longint link [3][3];
      longint lpos [3];
      longint nrot [3][3];
      longint npos [3];
      longint sq, cq, sa, ca, len, ofs, acc, sum;
      for (int r = 0; r < 3; r++) begin
         pos[r] = 0;
         for (int c = 0; c < 3; c++) begin
            rot[r][c] = (r == c) ? 16384 : 0;
         end
      end
      for (int j = 0; j < 6; j++) begin
         len = longint'(joint_word[j][19:0]);
         ofs = longint'($signed(joint_word[j][39:20]));
         cordic_sincos(angles[16*j +: 16], sq, cq);
         cordic_sincos(joint_word[j][55:40], sa, ca);
         link[0][0] = cq;
         link[0][1] = clamp16(-sq);
         link[0][2] = 0;
         link[1][0] = clamp16(round_q14(sq * ca));
         link[1][1] = clamp16(round_q14(cq * ca));
         link[1][2] = clamp16(-sa);
         link[2][0] = clamp16(round_q14(sq * sa));
         link[2][1] = clamp16(round_q14(cq * sa));
         link[2][2] = ca;
         lpos[0] = len;
         lpos[1] = clamp32(-round_q14(ofs * sa));
         lpos[2] = clamp32(round_q14(ofs * ca));
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               sum = 0;
               for (int k = 0; k < 3; k++) begin
                  sum += rot[r][k] * link[k][c];
               end
               nrot[r][c] = clamp16(round_q14(sum));
            end
            acc = 0;
            for (int k = 0; k < 3; k++) begin
               acc += rot[r][k] * lpos[k];
            end
            npos[r] = clamp32(round_q14(acc) + pos[r]);
         end
         rot = nrot;
         pos = npos;
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            pose.rot[3*r+c] = rot[r][c][15:0];
         end
         pose.pos[r] = pos[r][31:0];
      end
      return pose;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH %s at %0t", what, $realtime);
      error_count++;
   endtask

   // Drives requests (held until taken, then random gaps) and a random rsp_tready.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_taken) begin
            req_tvalid <= 1'b1;
         end else if (pose_requests.size() > 0 &&
                      $urandom_range(99, 0) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= pose_requests[0];
         end else begin
            req_tvalid <= 1'b0;
         end
         rsp_tready <= $urandom_range(99, 0) >= recv_idle_pct;
      end
   end

   // Predicts on each accepted request; checks each accepted response.
   always @(posedge clock) begin
      pose_type got;
      pose_type want;
      if (!reset) begin
         req_taken <= req_tvalid && req_tready;
         if ((req_tvalid && req_tready) || (csr_valid && csr_ready) ||
             (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (req_tvalid && req_tready) begin
            expected_poses.push_back(chain_pose(req_tdata));
            pose_requests.pop_front();
         end
         if (rsp_tvalid && rsp_tready) begin
            for (int i = 0; i < 9; i++) begin
               got.rot[i] = rsp_tdata[16*i +: 16];
            end
            for (int i = 0; i < 3; i++) begin
               got.pos[i] = rsp_tdata[144 + 32*i +: 32];
            end
            if (expected_poses.size() == 0) begin
               report_mismatch("unexpected response");
            end else begin
               want = expected_poses.pop_front();
               for (int i = 0; i < 9; i++) begin
                  if (got.rot[i] !== want.rot[i]) begin
                     report_mismatch($sformatf("rot_%0d%0d: got %0d, expected %0d",
                                     i / 3, i % 3, got.rot[i], want.rot[i]));
                  end
               end
               for (int i = 0; i < 3; i++) begin
                  if (got.pos[i] !== want.pos[i]) begin
                     report_mismatch($sformatf("pos_%0d: got %0d, expected %0d",
                                     i, got.pos[i], want.pos[i]));
                  end
               end
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (!done && quiet_cycles > 20000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic wait_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // Writes one parameter register through the csr channel while idle.
   task automatic write_joint(logic [2:0] index, logic [55:0] word);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= word;
      do @(posedge clock); while (!csr_ready);
      if (index < 6) begin
         joint_word[index] = word;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pose_requests.size() > 0 || req_tvalid || expected_poses.size() > 0) begin
         @(posedge clock);
      end
      wait_cycles(200);
   endtask

   function automatic logic [55:0] random_joint(int mode);
      logic [19:0] len;
      logic [19:0] ofs;
      logic [15:0] twist;
      len = 20'($urandom);
      ofs = 20'($urandom);
      twist = 16'($urandom);
      case (mode)
         0: begin
            len = 20'hFFFFF;
            ofs = 20'h80000;
         end
         1: begin
            len = '0;
            ofs = 20'h7FFFF;
         end
         2: twist = 16'(16'h4000 * $urandom_range(3, 0));
         default: ;
      endcase
      return {twist, ofs, len};
   endfunction

   function automatic logic [REQ_W-1:0] random_pose();
      logic [REQ_W-1:0] p;
      for (int j = 0; j < 6; j++) begin
         case ($urandom_range(7, 0))
            0: p[16*j +: 16] = 16'h8000;
            1: p[16*j +: 16] = 16'h7FFF;
            2: p[16*j +: 16] = 16'(16'h4000 * $urandom_range(3, 0));
            default: p[16*j +: 16] = 16'($urandom);
         endcase
      end
      return p;
   endfunction

   initial begin
      for (int j = 0; j < 6; j++) begin
         joint_word[j] = '0;
      end
      wait_cycles(8);
      @(negedge clock);
      reset = 1'b0;

      // Directed poses with all registers at zero.
      pose_requests.push_back('0);
      pose_requests.push_back({6{16'h8000}});
      pose_requests.push_back({6{16'h7FFF}});
      pose_requests.push_back({6{16'h4000}});
      pose_requests.push_back({6{16'hC000}});
      pose_requests.push_back({6{16'hFFFF}});
      drain();

      // Extreme parameters, plus two writes to out-of-range indexes.
      for (int j = 0; j < 6; j++) begin
         write_joint(3'(j), {16'h8000, 20'h80000, 20'hFFFFF});
      end
      write_joint(3'd6, '1);
      write_joint(3'd7, '0);
      pose_requests.push_back('0);
      pose_requests.push_back({6{16'h8000}});
      pose_requests.push_back({16'h4000, 16'hC000, 16'h7FFF, 16'h8001, 16'h2000, 16'hE000});
      drain();
      for (int j = 0; j < 6; j++) begin
         write_joint(3'(j), {16'h4000, 20'h7FFFF, 20'h00000});
      end
      pose_requests.push_back({6{16'h4000}});
      pose_requests.push_back({6{16'hC000}});
      pose_requests.push_back({6{16'h0001}});
      drain();

      // Random phases under three idle patterns, parameters changed between them.
      for (int phase = 0; phase < 9; phase++) begin
         send_idle_pct = phase < 3 ? 38 : (phase < 6 ? 66 : 0);
         recv_idle_pct = phase < 3 ? 66 : (phase < 6 ? 38 : 0);
         for (int j = 0; j < 6; j++) begin
            write_joint(3'(j), random_joint($urandom_range(4, 0)));
         end
         for (int n = 0; n < 210; n++) begin
            pose_requests.push_back(random_pose());
         end
         drain();
      end

      done = 1'b1;
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

>>> filelist.f
sv/mfk_pkg.sv
sv/mfk_cordic.sv
sv/mfk_front.sv
sv/mfk_queue.sv
sv/mfk_back.sv
sv/mdh_forward_kinematics_6axis_top.sv
sim/tb_mdh_forward_kinematics_6axis_top.sv
